[rtl/nvwt_pkg.sv]
// ----------------------------------------------------------------------------
// nvwt_pkg
// Shared widths, codes and controller/datapath interface types for the
// nearest vertex weight transfer block.
// ----------------------------------------------------------------------------
package nvwt_pkg;

  // Default storage parameters
  localparam int DEF_MAX_POINTS = 1024;
  localparam int DEF_MAX_JOINTS = 64;
  localparam int DEF_COORD_BITS = 24;

  // Fixed field widths
  localparam int CMD_W       = 2;
  localparam int PIDX_W      = 10;
  localparam int JSEL_W      = 6;
  localparam int FCOORD_W    = 24;
  localparam int WEIGHT_W    = 16;
  localparam int SRC_CNT_W   = 11;
  localparam int JNT_CNT_W   = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_POS    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JOINT_COUNT  = 1'd1;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;      // input transfer this cycle
    logic scan_start;  // query accepted: latch target, rewind point counter
    logic scan_issue;  // read one stored point into the distance pipe
    logic emit_start;  // compute weight row base of the winner
    logic emit_issue;  // read one weight and present it next cycle
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;   // point counter is at the final point
    logic pipe_busy;   // distance pipe still holds points
    logic emit_last;   // joint counter is at the final joint
  } dp_status_t;

endpackage

[rtl/nvwt_dist.sv]
// ----------------------------------------------------------------------------
// nvwt_dist
// Three stage squared distance pipe: absolute differences, squares, then a
// saturating sum. Point index travels alongside each distance.
// ----------------------------------------------------------------------------
module nvwt_dist #(
  parameter int COORD_BITS = nvwt_pkg::DEF_COORD_BITS,
  parameter int IDX_BITS   = nvwt_pkg::PIDX_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [IDX_BITS-1:0]          in_idx,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] pz,
  input  logic signed [COORD_BITS-1:0] tx,
  input  logic signed [COORD_BITS-1:0] ty,
  input  logic signed [COORD_BITS-1:0] tz,
  output logic                         out_valid,
  output logic [IDX_BITS-1:0]          out_idx,
  output logic [((2*COORD_BITS+2 > 64) ? 64 : 2*COORD_BITS+2)-1:0] out_dist,
  output logic                         busy
);

  localparam int DW = 2 * COORD_BITS + 2;
  localparam int SW = (DW > 64) ? 64 : DW;

  logic signed [COORD_BITS:0]   dx, dy, dz;
  logic [COORD_BITS-1:0]        mx_next, my_next, mz_next;
  logic [COORD_BITS-1:0]        mx, my, mz;
  logic [2*COORD_BITS-1:0]      sx, sy, sz;
  logic [DW-1:0]                sum;
  logic                         v1, v2;
  logic [IDX_BITS-1:0]          i1, i2;

  // Stage 1: absolute coordinate differences
  always_comb begin
    dx = {px[COORD_BITS-1], px} - {tx[COORD_BITS-1], tx};
    dy = {py[COORD_BITS-1], py} - {ty[COORD_BITS-1], ty};
    dz = {pz[COORD_BITS-1], pz} - {tz[COORD_BITS-1], tz};
    mx_next = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    my_next = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    mz_next = dz[COORD_BITS] ? COORD_BITS'(-dz) : COORD_BITS'(dz);
  end

  always_ff @(posedge clk) begin
    mx <= mx_next;
    my <= my_next;
    mz <= mz_next;
    i1 <= in_idx;
  end

  // Stage 2: squares
  always_ff @(posedge clk) begin
    sx <= mx * mx;
    sy <= my * my;
    sz <= mz * mz;
    i2 <= i1;
  end

  // Stage 3: sum, clamped to 64 bits for the widest coordinates
  assign sum = DW'(sx) + DW'(sy) + DW'(sz);

  always_ff @(posedge clk) begin
    if (sum > DW'({SW{1'b1}})) begin
      out_dist <= {SW{1'b1}};
    end else begin
      out_dist <= SW'(sum);
    end
    out_idx <= i2;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  assign busy = v1 | v2 | out_valid;

endmodule

[rtl/nvwt_datapath.sv]
// ----------------------------------------------------------------------------
// nvwt_datapath
// Point and weight stores, configuration registers, scan counter, distance
// pipe, best point tracker, and the result registers.
// ----------------------------------------------------------------------------
module nvwt_datapath #(
  parameter int MAX_POINTS = nvwt_pkg::DEF_MAX_POINTS,
  parameter int MAX_JOINTS = nvwt_pkg::DEF_MAX_JOINTS,
  parameter int COORD_BITS = nvwt_pkg::DEF_COORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  nvwt_pkg::ctrl_cmd_t                 cmd,
  output nvwt_pkg::dp_status_t                stat,
  input  logic [nvwt_pkg::CMD_W-1:0]          command,
  input  logic [nvwt_pkg::PIDX_W-1:0]         point_index,
  input  logic [nvwt_pkg::JSEL_W-1:0]         joint_select,
  input  logic signed [nvwt_pkg::FCOORD_W-1:0] x_coord,
  input  logic signed [nvwt_pkg::FCOORD_W-1:0] y_coord,
  input  logic signed [nvwt_pkg::FCOORD_W-1:0] z_coord,
  input  logic [nvwt_pkg::WEIGHT_W-1:0]       weight_value,
  input  logic                                cfg_write,
  input  logic [nvwt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nvwt_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                result_valid,
  output logic [nvwt_pkg::WEIGHT_W-1:0]       out_weight,
  output logic [nvwt_pkg::JSEL_W-1:0]         out_joint,
  output logic [nvwt_pkg::PIDX_W-1:0]         nearest_point,
  output logic                                last_of_row
);

  localparam int PW    = $clog2(MAX_POINTS);
  localparam int JW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int NCW   = (PW + 1 > nvwt_pkg::SRC_CNT_W) ? PW + 1 : nvwt_pkg::SRC_CNT_W;
  localparam int JCW   = (JW + 1 > nvwt_pkg::JNT_CNT_W) ? JW + 1 : nvwt_pkg::JNT_CNT_W;
  localparam int WDEPTH = MAX_POINTS * MAX_JOINTS;
  localparam int WAW   = $clog2(WDEPTH);
  localparam int DW    = 2 * COORD_BITS + 2;
  localparam int SW    = (DW > 64) ? 64 : DW;

  // Configuration registers
  logic [nvwt_pkg::SRC_CNT_W-1:0] source_count;
  logic [nvwt_pkg::JNT_CNT_W-1:0] joint_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_count <= nvwt_pkg::SRC_CNT_W'(1);
      joint_count  <= nvwt_pkg::JNT_CNT_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        nvwt_pkg::REG_SOURCE_COUNT: source_count <= cfg_data;
        nvwt_pkg::REG_JOINT_COUNT:  joint_count  <= nvwt_pkg::JNT_CNT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Counts clamped to what the stores hold
  logic [NCW-1:0] src_ext, n_eff;
  logic [JCW-1:0] jnt_ext, jn_eff;

  always_comb begin
    src_ext = NCW'(source_count);
    jnt_ext = JCW'(joint_count);
    if (src_ext == '0) begin
      n_eff = NCW'(1);
    end else if (src_ext > NCW'(MAX_POINTS)) begin
      n_eff = NCW'(MAX_POINTS);
    end else begin
      n_eff = src_ext;
    end
    if (jnt_ext == '0) begin
      jn_eff = JCW'(1);
    end else if (jnt_ext > JCW'(MAX_JOINTS)) begin
      jn_eff = JCW'(MAX_JOINTS);
    end else begin
      jn_eff = jnt_ext;
    end
  end

  // Incoming coordinates wrapped to the stored width
  logic signed [COORD_BITS-1:0] xc, yc, zc;
  assign xc = COORD_BITS'(x_coord);
  assign yc = COORD_BITS'(y_coord);
  assign zc = COORD_BITS'(z_coord);

  logic pos_we, wt_we;
  assign pos_we = cmd.accept && (command == nvwt_pkg::CMD_POS) &&
                  (32'(point_index) < MAX_POINTS);
  assign wt_we  = cmd.accept && (command == nvwt_pkg::CMD_WEIGHT) &&
                  (32'(point_index) < MAX_POINTS) && (32'(joint_select) < MAX_JOINTS);

  // Target latch
  logic signed [COORD_BITS-1:0] tx, ty, tz;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      tx <= xc;
      ty <= yc;
      tz <= zc;
    end
  end

  // Scan counter
  logic [PW-1:0] pt_cnt;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      pt_cnt <= '0;
    end else if (cmd.scan_issue) begin
      pt_cnt <= pt_cnt + PW'(1);
    end
  end

  assign stat.scan_last = (NCW'(pt_cnt) == n_eff - NCW'(1));

  // Position store: write on command, registered read during scan
  logic [3*COORD_BITS-1:0] pos_mem [MAX_POINTS];
  logic [3*COORD_BITS-1:0] pos_q;
  logic [PW-1:0]           rd_idx;
  logic                    rd_v;

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[PW'(point_index)] <= {xc, yc, zc};
    end
    pos_q  <= pos_mem[pt_cnt];
    rd_idx <= pt_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= cmd.scan_issue;
    end
  end

  // Distance pipe
  logic          d_valid, d_busy;
  logic [PW-1:0] d_idx;
  logic [SW-1:0] d_dist;

  nvwt_dist #(
    .COORD_BITS (COORD_BITS),
    .IDX_BITS   (PW)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_v),
    .in_idx    (rd_idx),
    .px        (pos_q[3*COORD_BITS-1:2*COORD_BITS]),
    .py        (pos_q[2*COORD_BITS-1:COORD_BITS]),
    .pz        (pos_q[COORD_BITS-1:0]),
    .tx        (tx),
    .ty        (ty),
    .tz        (tz),
    .out_valid (d_valid),
    .out_idx   (d_idx),
    .out_dist  (d_dist),
    .busy      (d_busy)
  );

  assign stat.pipe_busy = rd_v | d_busy;

  // Best point tracker; first point always wins, ties keep the lower index
  logic [PW-1:0] best_idx;
  logic [SW-1:0] best_dist;

  always_ff @(posedge clk) begin
    if (d_valid && ((d_idx == '0) || (d_dist < best_dist))) begin
      best_idx  <= d_idx;
      best_dist <= d_dist;
    end
  end

  // Weight row walk
  logic [WAW-1:0] row_base;
  logic [JW-1:0]  jnt_cnt;

  always_ff @(posedge clk) begin
    if (cmd.emit_start) begin
      row_base <= WAW'(best_idx * MAX_JOINTS);
      jnt_cnt  <= '0;
    end else if (cmd.emit_issue) begin
      jnt_cnt  <= jnt_cnt + JW'(1);
    end
  end

  assign stat.emit_last = (JCW'(jnt_cnt) == jn_eff - JCW'(1));

  // Weight store: write on command, registered read feeds the result port
  logic [nvwt_pkg::WEIGHT_W-1:0] wt_mem [WDEPTH];
  logic [WAW-1:0]                wt_waddr, wt_raddr;

  assign wt_waddr = WAW'(32'(point_index) * MAX_JOINTS + 32'(joint_select));
  assign wt_raddr = row_base + WAW'(jnt_cnt);

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= weight_value;
    end
    out_weight <= wt_mem[wt_raddr];
  end

  // Result registers
  always_ff @(posedge clk) begin
    out_joint     <= nvwt_pkg::JSEL_W'(jnt_cnt);
    nearest_point <= nvwt_pkg::PIDX_W'(best_idx);
    last_of_row   <= stat.emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_issue;
    end
  end

endmodule

[rtl/nvwt_ctrl.sv]
// ----------------------------------------------------------------------------
// nvwt_ctrl
// Sequencer: accepts commands, runs the point scan, waits for the distance
// pipe to drain, then walks the winner's weight row.
// ----------------------------------------------------------------------------
module nvwt_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [nvwt_pkg::CMD_W-1:0] command,
  input  nvwt_pkg::dp_status_t       stat,
  output nvwt_pkg::ctrl_cmd_t        cmd,
  output logic                       busy
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.accept     = start;
        cmd.scan_start = start && (command == nvwt_pkg::CMD_QUERY);
        if (cmd.scan_start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.emit_start = 1'b1;
          state_next     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit_issue = 1'b1;
        if (stat.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

[rtl/nearest_vertex_weight_transfer.sv]
// ----------------------------------------------------------------------------
// nearest_vertex_weight_transfer
// Brute force nearest point search over stored source points, then output
// of the winner's per-joint weights, one result transfer per joint.
// Writes (commands 0 and 1) are taken while idle; busy stays low.
// A query scans n points at one per cycle through a 4-deep read/distance
// pipe, then walks the winner's weight row; busy is high through the scan,
// drain and walk. Results are strobed for one cycle; no stall.
// Reset: synchronous; counts go to 1, the stores are not cleared.
// ----------------------------------------------------------------------------
module nearest_vertex_weight_transfer #(
  parameter int MAX_POINTS = nvwt_pkg::DEF_MAX_POINTS,
  parameter int MAX_JOINTS = nvwt_pkg::DEF_MAX_JOINTS,
  parameter int COORD_BITS = nvwt_pkg::DEF_COORD_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [nvwt_pkg::CMD_W-1:0]           command,
  input  logic [nvwt_pkg::PIDX_W-1:0]          point_index,
  input  logic [nvwt_pkg::JSEL_W-1:0]          joint_select,
  input  logic signed [nvwt_pkg::FCOORD_W-1:0] x_coord,
  input  logic signed [nvwt_pkg::FCOORD_W-1:0] y_coord,
  input  logic signed [nvwt_pkg::FCOORD_W-1:0] z_coord,
  input  logic [nvwt_pkg::WEIGHT_W-1:0]        weight_value,
  input  logic                                 cfg_write,
  input  logic [nvwt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nvwt_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                 result_valid,
  output logic [nvwt_pkg::WEIGHT_W-1:0]        out_weight,
  output logic [nvwt_pkg::JSEL_W-1:0]          out_joint,
  output logic [nvwt_pkg::PIDX_W-1:0]          nearest_point,
  output logic                                 last_of_row
);

  nvwt_pkg::ctrl_cmd_t  cmd;
  nvwt_pkg::dp_status_t stat;

  // Sequencer
  nvwt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Stores, scan and result path
  nvwt_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_JOINTS (MAX_JOINTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .command       (command),
    .point_index   (point_index),
    .joint_select  (joint_select),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .z_coord       (z_coord),
    .weight_value  (weight_value),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .out_weight    (out_weight),
    .out_joint     (out_joint),
    .nearest_point (nearest_point),
    .last_of_row   (last_of_row)
  );

endmodule
